// ----- hdl/abe_pkg.sv -----
// Shared types and constants for the three-to-four printable character encoder.
// No dependencies.
`default_nettype none

package abe_pkg;

   localparam int CODE_W = 6;
   localparam int CHAR_W = 7;
   localparam int CODES_PER_GROUP = 4;

   localparam logic [CHAR_W-1:0] CHAR_BIAS   = 7'h20;
   localparam logic [CHAR_W-1:0] ESCAPE_CHAR = 7'h5c;

   // One complete group of four six-bit codes, ready for serialization.
   typedef struct packed {
      logic [CODES_PER_GROUP-1:0][CODE_W-1:0] codes;
      logic                                   final_group;
   } group_type;

   // Front to queue: write side.
   typedef struct packed {
      logic      valid;
      group_type group;
   } group_push_type;

   // Queue to back: head of queue.
   typedef struct packed {
      logic      valid;
      group_type group;
   } group_head_type;

endpackage

`default_nettype wire

// ----- hdl/abe_front.sv -----
// Front end: accepts bytes, collects groups of three, splits them into six-bit codes.
// Depends on abe_pkg.
`default_nettype none

module abe_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_end_of_message,
   input  wire logic                  queue_full,
   output abe_pkg::group_push_type    push
);

   logic [7:0] held_first_ff, held_first_in;
   logic [7:0] held_second_ff, held_second_in;
   logic [1:0] position_ff, position_in;
   logic       accept;
   logic [7:0] b0, b1, b2;
   logic       emit;
   logic       final_group;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      position_in    = position_ff;
      b0             = req_data_byte;
      b1             = 8'h00;
      b2             = 8'h00;
      emit           = 1'b0;
      final_group    = 1'b1;
      case (position_ff)
         2'd1: begin
            b0 = held_first_ff;
            b1 = req_data_byte;
            if (req_end_of_message) begin
               emit = 1'b1;
            end else if (accept) begin
               held_second_in = req_data_byte;
               position_in    = 2'd2;
            end
         end
         2'd2: begin
            b0          = held_first_ff;
            b1          = held_second_ff;
            b2          = req_data_byte;
            emit        = 1'b1;
            final_group = req_end_of_message;
         end
         default: begin
            // start of group (position 3 never arises, treated the same)
            if (req_end_of_message) begin
               emit = 1'b1;
            end else if (accept) begin
               held_first_in = req_data_byte;
               position_in   = 2'd1;
            end
         end
      endcase
      if (accept && emit) begin
         held_first_in  = 8'h00;
         held_second_in = 8'h00;
         position_in    = 2'd0;
      end
   end

   always_comb begin
      push.valid             = accept && emit;
      push.group.codes[0]    = b0[5:0];
      push.group.codes[1]    = {b1[3:0], b0[7:6]};
      push.group.codes[2]    = {b2[1:0], b1[7:4]};
      push.group.codes[3]    = b2[7:2];
      push.group.final_group = final_group;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_first_ff  <= 8'h00;
         held_second_ff <= 8'h00;
         position_ff    <= 2'd0;
      end else begin
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
         position_ff    <= position_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/abe_queue.sv -----
// Short group queue between front and back end.
// Depends on abe_pkg.
`default_nettype none

module abe_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire abe_pkg::group_push_type push,
   input  wire logic                  pop,
   output logic                       full,
   output abe_pkg::group_head_type    head
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   abe_pkg::group_type  entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == COUNT_W'(DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.group = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- hdl/abe_back.sv -----
// Back end: serializes queued groups into characters, inserting escapes.
// Depends on abe_pkg.
`default_nettype none

module abe_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               escape_spaces,
   input  wire abe_pkg::group_head_type            head,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [abe_pkg::CHAR_W-1:0]              rsp_char_out,
   output logic                                    rsp_last_char
);

   logic [1:0]                   index_ff, index_in;
   logic                         esc_done_ff, esc_done_in;
   logic                         valid_ff, valid_in;
   logic [abe_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic                         last_ff, last_in;
   logic [abe_pkg::CODE_W-1:0]   code;
   logic                         load;
   logic                         need_escape;

   assign code        = head.group.codes[index_ff];
   assign load        = head.valid && (!valid_ff || !rsp_stall);
   assign need_escape = escape_spaces && (code == '0) && !esc_done_ff;

   always_comb begin
      index_in    = index_ff;
      esc_done_in = esc_done_ff;
      valid_in    = valid_ff;
      char_in     = char_ff;
      last_in     = last_ff;
      pop         = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (need_escape) begin
            char_in     = abe_pkg::ESCAPE_CHAR;
            last_in     = 1'b0;
            esc_done_in = 1'b1;
         end else begin
            char_in     = abe_pkg::CHAR_W'(code) + abe_pkg::CHAR_BIAS;
            last_in     = head.group.final_group && (index_ff == 2'd3);
            esc_done_in = 1'b0;
            index_in    = index_ff + 1'b1;
            pop         = (index_ff == 2'd3);
         end
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= 2'd0;
         esc_done_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         index_ff    <= index_in;
         esc_done_ff <= esc_done_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_out  = char_ff;
   assign rsp_last_char = last_ff;

   // backslash never closes a message
   a_escape_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (char_ff == abe_pkg::ESCAPE_CHAR) && esc_done_ff |-> !last_ff)
      else $error("escape beat flagged last");

   // a pending escape means the backslash sits in the output register
   a_escape_in_output: assert property (@(posedge clock) disable iff (reset)
      esc_done_ff |-> valid_ff && (char_ff == abe_pkg::ESCAPE_CHAR))
      else $error("escape flag without backslash in output");

   // after a backslash is loaded, the next load is the space itself
   a_space_follows: assert property (@(posedge clock) disable iff (reset)
      esc_done_ff && load |-> !need_escape && (code == '0))
      else $error("escape not followed by space");

   // a group is retired only while it is present
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- hdl/ascii64_byte_encoder.sv -----
// Top level of the three-to-four printable character encoder.
// Depends on abe_pkg, abe_front, abe_queue, abe_back.
//
// Bytes arrive one beat at a time on req_; every three bytes become four
// characters 0x20..0x5f on rsp_, one character per beat, six-bit groups taken
// least significant bit first. A byte with req_end_of_message closes the
// message: a partial group is padded with zero bytes and the last character
// carries rsp_last_char. With csr escape set, every encoded space is preceded
// by a backslash (never flagged last). The front end takes one byte per cycle
// while the group queue has room; the back end emits one character per cycle
// while rsp_stall is low, so a group yields four characters plus one backslash
// per escaped space (four to eight), and the single output serializer sets the
// sustained rate. The third byte of a group is written into the group queue, and
// its first character is then loaded into the output register. Write csr only while the block is idle.
`default_nettype none

module ascii64_byte_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [6:0]       rsp_char_out,
   output logic             rsp_last_char,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   // escape setting register
   logic escape_spaces_ff, escape_spaces_in;

   abe_pkg::group_push_type push;
   abe_pkg::group_head_type head;
   logic                    queue_full;
   logic                    pop;

   assign escape_spaces_in = csr_wr_en ? csr_wr_data : escape_spaces_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_spaces_ff <= 1'b0;
      end else begin
         escape_spaces_ff <= escape_spaces_in;
      end
   end

   // front end: grouping and bit slicing
   abe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .queue_full         (queue_full),
      .push               (push)
   );

   // decouples byte intake from character output
   abe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // back end: one character per beat, escape insertion, output register
   abe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .escape_spaces (escape_spaces_ff),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_char (rsp_last_char)
   );

endmodule

`default_nettype wire

// ----- verif/abe_tb_pkg.sv -----
`timescale 1ns / 1ps
// Character scoreboard for the ascii64 byte encoder testbench: keeps its own copy
// of the group state, predicts the characters each accepted byte causes, checks beats.
// Depends on abe_pkg for character width and the bias and escape constants.
package abe_tb_pkg;

   // how many bytes of the open group are held
   typedef enum logic [1:0] {GRP_EMPTY, GRP_ONE, GRP_TWO} group_fill_type;

   typedef struct packed {
      logic [abe_pkg::CHAR_W-1:0] char_code;
      logic                       last;
   } encoded_char_type;

   class char_scoreboard;
      bit               escape_on;
      logic [7:0]       first_byte;
      logic [7:0]       second_byte;
      group_fill_type   fill;
      encoded_char_type expected_chars[$];
      int               errors;

      function new();
         escape_on   = 1'b0;
         first_byte  = '0;
         second_byte = '0;
         fill        = GRP_EMPTY;
         errors      = 0;
      endfunction

      function void set_escape(bit value);
         escape_on = value;
      endfunction

      // Splits three bytes into four six-bit codes, LSB first, and queues the characters.
      function void encode_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                 logic final_group);
         logic [abe_pkg::CODE_W-1:0] codes [4];
         logic [abe_pkg::CHAR_W-1:0] ch;
         codes[0] = b0[5:0];
         codes[1] = {b1[3:0], b0[7:6]};
         codes[2] = {b2[1:0], b1[7:4]};
         codes[3] = b2[7:2];
         for (int k = 0; k < 4; k++) begin
            ch = abe_pkg::CHAR_BIAS + {1'b0, codes[k]};
            // backslash is never flagged last
            if (escape_on && ch == abe_pkg::CHAR_BIAS)
               expected_chars.push_back('{abe_pkg::ESCAPE_CHAR, 1'b0});
            expected_chars.push_back('{ch, final_group && k == 3});
         end
      endfunction

      // Called once per accepted input beat.
      function void note_byte(logic [7:0] data, logic eom);
         case (fill)
            GRP_ONE: begin
               if (!eom) begin
                  second_byte = data;
                  fill = GRP_TWO;
                  return;
               end
               encode_group(first_byte, data, 8'h00, 1'b1);
            end
            GRP_TWO: encode_group(first_byte, second_byte, data, eom);
            default: begin
               if (!eom) begin
                  first_byte = data;
                  fill = GRP_ONE;
                  return;
               end
               encode_group(data, 8'h00, 8'h00, 1'b1);
            end
         endcase
         first_byte  = '0;
         second_byte = '0;
         fill        = GRP_EMPTY;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40)
            $display("[%0t] ERROR: %s", $time, msg);
      endtask

      // Called once per accepted result beat.
      task check_char(logic [abe_pkg::CHAR_W-1:0] char_code, logic last);
         encoded_char_type want;
         if (expected_chars.size() == 0) begin
            report($sformatf("unexpected char 0x%02h last=%0b", char_code, last));
            return;
         end
         want = expected_chars.pop_front();
         if (char_code !== want.char_code)
            report($sformatf("char 0x%02h, want 0x%02h", char_code, want.char_code));
         if (last !== want.last)
            report($sformatf("last_char %0b on char 0x%02h, want %0b",
                             last, char_code, want.last));
      endtask
   endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the ascii64 byte encoder testbench: clock, reset, beat drivers, monitors.
// Depends on abe_pkg, abe_tb_pkg and the ascii64_byte_encoder RTL.
module tb_top;

   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 8;     // margin for the block to settle
   localparam int HOLD_OFF_CYCLES = 120;   // long enough to fill the group queue
   localparam int PHASE_BYTES     = 20;
   localparam int NUM_PHASES      = 6;
   localparam int CYCLE_LIMIT     = 300000;

   logic             clock              = 1'b0;
   logic             reset              = 1'b1;
   logic             req_valid          = 1'b0;
   logic [7:0]       req_data_byte      = 8'h00;
   logic             req_end_of_message = 1'b0;
   logic             rsp_stall          = 1'b0;
   logic             csr_wr_en          = 1'b0;
   logic             csr_wr_data        = 1'b0;
   logic             req_stall;
   logic             rsp_valid;
   logic [abe_pkg::CHAR_W-1:0] rsp_char_out;
   logic             rsp_last_char;

   abe_tb_pkg::char_scoreboard sb;
   int unsigned      send_gap_pct  = 0;    // chance of a sender gap after each beat
   int unsigned      stall_pct     = 0;    // chance of a receiver stall burst per cycle
   bit               hold_off_now  = 1'b0; // one-shot request for the long receiver hold
   int unsigned      cycle_count   = 0;

   ascii64_byte_encoder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_char_out       (rsp_char_out),
      .rsp_last_char      (rsp_last_char),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Runaway guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Monitors sample at the falling edge: inputs only move at the rising edge,
   // so what is seen here is exactly what the next rising edge will take.
   always @(negedge clock) begin
      if (!reset && req_valid && req_stall === 1'b0)
         sb.note_byte(req_data_byte, req_end_of_message);
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_char(rsp_char_out, rsp_last_char);
   end

   // Receiver: random stall bursts, plus the long hold when asked. The hold
   // is counted here so the sender keeps offering bytes meanwhile.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_now) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_now = 1'b0;
         end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // One input beat. Called at a rising edge; returns at the rising edge that
   // took the beat, or after the gap that follows it.
   task automatic send_byte(logic [7:0] data, logic eom);
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_end_of_message <= eom;
      do @(negedge clock); while (req_stall !== 1'b0);
      @(posedge clock);
      if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Stop offering, wait for every expected character, then let the block settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_escape(bit value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_escape(value);
   endtask

   // Bias toward zero bits so encoded spaces (and escapes) show up often.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0, 1:    return 8'h00;
         2:       return 8'hff;
         3:       return 8'($urandom_range(0, 255)) & 8'hc0;
         4:       return 8'($urandom_range(0, 255)) & 8'h3f;
         5:       return 8'($urandom_range(0, 255)) & 8'h0f;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Random messages until the byte budget of the phase is used; mostly short,
   // sometimes long. Each one ends with end_of_message so the block ends idle.
   task automatic send_messages(int unsigned budget);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < budget) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
         for (int unsigned i = 1; i <= len; i++)
            send_byte(pick_byte(), i == len);
         sent += len;
      end
   endtask

   initial begin
      sb = new();
      send_gap_pct = 20;
      stall_pct    = 20;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, escape off (reset value).
      // full group not at end of message
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      // end of message on the first byte of a group: two zero pad bytes
      send_byte(8'h80, 1'b1);
      // end on the second byte: one pad byte, held bytes must be clear again
      send_byte(8'h3f, 1'b0);
      send_byte(8'hc3, 1'b1);
      // full group closing the message
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b1);
      wait_drained();

      // Directed, escape on.
      write_escape(1'b1);
      // all-zero lone byte: four spaces, each escaped, the last one flagged last
      send_byte(8'h00, 1'b1);
      // escaped final space after non-space characters
      send_byte(8'hff, 1'b0);
      send_byte(8'h0f, 1'b0);
      send_byte(8'h00, 1'b1);
      // eight-beat group not at end, then a lone closing byte
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      // one space among non-spaces in a short message
      send_byte(8'h41, 1'b0);
      send_byte(8'h10, 1'b1);
      wait_drained();

      // Random phases, alternating the escape setting.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_escape(1'(phase % 2));
         case (phase)
            0: begin send_gap_pct = 30; stall_pct = 30; end
            1: begin
               // receiver holds off while bytes keep coming: queue fills, input stalls
               send_gap_pct = 0;
               stall_pct    = 10;
               hold_off_now = 1'b1;
            end
            2: begin send_gap_pct = 0;  stall_pct = 0;  end
            3: begin send_gap_pct = 50; stall_pct = 50; end
            4: begin send_gap_pct = 15; stall_pct = 40; end
            default: begin send_gap_pct = 0; stall_pct = 0; end
         endcase
         send_messages(PHASE_BYTES);
         wait_drained();
      end

      if (sb.expected_chars.size() != 0)
         sb.report($sformatf("%0d expected chars never arrived", sb.expected_chars.size()));
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/abe_pkg.sv
hdl/abe_front.sv
hdl/abe_queue.sv
hdl/abe_back.sv
hdl/ascii64_byte_encoder.sv
verif/abe_tb_pkg.sv
verif/tb_top.sv
